// ----- rtl/ray_unit_cube_intersect_macros.svh -----
// Assertion macros shared by the ray / unit cube intersection RTL.
`ifndef RAY_UNIT_CUBE_INTERSECT_MACROS_SVH
`define RAY_UNIT_CUBE_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define RUCI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ruci: assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define RUCI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ruci: assertion failed");
`else
`define RUCI_ASSERT_IMP(lbl, ante, cons)
`define RUCI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ruci_pkg.sv -----
// Shared constants, item types and face tables for the ray / unit cube intersection block.
package ruci_pkg;

  // Coordinate format: signed, CW bits, FB fraction bits
  localparam int CW = 32;
  localparam int FB = 16;
  // Internal t width (magnitude capped at 2^62)
  localparam int TW = 64;
  // Slab divider: numerator magnitude width and quotient width
  localparam int NW = CW + 1;
  localparam int NB = NW + FB;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic signed [CW-1:0] HALF    = CW'(64'd1 << (FB - 1));
  localparam logic signed [CW-1:0] QUARTER = CW'(64'd1 << (FB - 2));

  // Alignment of a Q.FB value onto Q0.16
  localparam int SH_R = (FB >= 16) ? FB - 16 : 0;
  localparam int SH_L = (FB < 16) ? 16 - FB : 0;

  // Face codes
  localparam logic [2:0] FACE_NX = 3'd0;
  localparam logic [2:0] FACE_PX = 3'd1;
  localparam logic [2:0] FACE_NY = 3'd2;
  localparam logic [2:0] FACE_PY = 3'd3;
  localparam logic [2:0] FACE_NZ = 3'd4;
  localparam logic [2:0] FACE_PZ = 3'd5;

  // Axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } ruci_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_hit;
    logic [2:0]           face;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [15:0]          tex_u;
    logic [15:0]          tex_v;
  } ruci_out_t;

  // Classified ray, as handed from the front end to the back end
  typedef struct packed {
    logic                 par_miss;  // some parallel axis lies outside its slab
    logic [2:0]           dzero;     // direction component is zero
    logic [2:0]           dneg;
    logic [2:0][CW-1:0]   dmag;
    logic [2:0]           aneg;      // sign of -0.5 - origin
    logic [2:0][NW-1:0]   amag;
    logic [2:0]           bneg;      // sign of +0.5 - origin
    logic [2:0][NW-1:0]   bmag;
    logic [2:0][CW-1:0]   org;
  } ruci_cls_t;

  // Cube-map selection per face: u/v source axis and quarter offset
  typedef struct packed {
    logic [1:0] uax;
    logic [1:0] uoff;
    logic [1:0] vax;
    logic [1:0] voff;
  } ruci_uv_sel_t;

  function automatic ruci_uv_sel_t uv_sel(input logic [2:0] face);
    ruci_uv_sel_t s;
    case (face)
      FACE_NX: s = '{uax: AX_Y, uoff: 2'd1, vax: AX_Z, voff: 2'd3};
      FACE_PX: s = '{uax: AX_Y, uoff: 2'd1, vax: AX_Z, voff: 2'd1};
      FACE_NY: s = '{uax: AX_X, uoff: 2'd1, vax: AX_Z, voff: 2'd3};
      FACE_PY: s = '{uax: AX_X, uoff: 2'd0, vax: AX_Z, voff: 2'd1};
      FACE_NZ: s = '{uax: AX_Y, uoff: 2'd1, vax: AX_X, voff: 2'd0};
      FACE_PZ: s = '{uax: AX_Y, uoff: 2'd2, vax: AX_X, voff: 2'd1};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/ray_unit_cube_intersect.sv -----
// Top level of the ray / unit cube slab intersection block.
// Usage:
//   Input channel: present a ray on in_data (origin and direction, signed Q16.16)
//   with push high; it is taken on a clock edge where full is low.
//   Result channel: while empty is low, out_data holds the oldest result (hit flag,
//   saturated t, face, hit point, cube-map UV; all zero on a miss); raise pop to
//   take it. Results leave in the order the rays came in, one per ray.
// Pipeline: front register, queue, slab dividers (one quotient bit per stage), then
//   slab selection, hit point, UV and the result register.
// Throughput: one ray per cycle sustained while results are popped, set by the fully
//   pipelined dividers and the split 32x32 multipliers of the hit-point stage.
// Stalls: when pop stays low with a result waiting, the back end holds in place;
//   the front end keeps taking rays into its register and the queue between the
//   two until both are full, then full rises.
// Reset: synchronous, rst_n low; all valid state clears, the block is empty and
//   ready to accept once reset is released.
module ray_unit_cube_intersect import ruci_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ruci_in_t  in_data,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output ruci_out_t out_data
);

  logic      fq_push, fq_full;
  ruci_cls_t fq_data;
  logic      qb_pop, qb_empty;
  ruci_cls_t qb_data;

  // Accept and classify
  ruci_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_push  (fq_push),
    .q_data  (fq_data),
    .q_full  (fq_full)
  );

  // Decoupling queue
  ruci_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (qb_pop),
    .rdata (qb_data),
    .empty (qb_empty)
  );

  // Divide, select, hit point, UV
  ruci_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_pop    (qb_pop),
    .q_data   (qb_data),
    .q_empty  (qb_empty),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ----- rtl/ruci_front.sv -----
// Front end: accepts rays and classifies them into slab numerators and direction magnitudes.
module ruci_front import ruci_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ruci_in_t  in_data,
  output logic      full,
  output logic      q_push,
  output ruci_cls_t q_data,
  input  logic      q_full
);

  logic      valid_r, valid_nxt;
  ruci_cls_t cls_r, cls_nxt;
  logic      accept;

  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];

  assign org[0] = in_data.origin_x;
  assign org[1] = in_data.origin_y;
  assign org[2] = in_data.origin_z;
  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  // One-entry holding register in front of the queue
  assign full      = valid_r && q_full;
  assign accept    = push && !full;
  assign q_push    = valid_r && !q_full;
  assign q_data    = cls_r;
  assign valid_nxt = accept || (valid_r && q_full);

  // Classification: slab numerators, magnitudes, signs, parallel test
  always_comb begin
    logic signed [CW+1:0] om, hx, na, nb, nna, nnb;
    logic [CW-1:0]        dn;
    cls_nxt = '0;
    hx = {2'b00, HALF};
    for (int i = 0; i < 3; i++) begin
      om  = {{2{org[i][CW-1]}}, org[i]};
      na  = -hx - om;
      nb  = hx - om;
      nna = -na;
      nnb = -nb;
      dn  = -dir[i];
      cls_nxt.aneg[i]  = na[CW+1];
      cls_nxt.amag[i]  = na[CW+1] ? nna[NW-1:0] : na[NW-1:0];
      cls_nxt.bneg[i]  = nb[CW+1];
      cls_nxt.bmag[i]  = nb[CW+1] ? nnb[NW-1:0] : nb[NW-1:0];
      cls_nxt.dzero[i] = (dir[i] == '0);
      cls_nxt.dneg[i]  = dir[i][CW-1];
      cls_nxt.dmag[i]  = dir[i][CW-1] ? dn : dir[i];
      cls_nxt.org[i]   = org[i];
      if ((dir[i] == '0) && ((org[i] < -HALF) || (org[i] > HALF))) begin
        cls_nxt.par_miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

// ----- rtl/ruci_queue.sv -----
// Short queue of classified rays between the front end and the back end.
`include "ray_unit_cube_intersect_macros.svh"
module ruci_queue import ruci_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ruci_cls_t wdata,
  output logic      full,
  input  logic      pop,
  output ruci_cls_t rdata,
  output logic      empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  ruci_cls_t       mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push_ok, pop_ok;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  // Pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_ok) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop_ok) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= wdata;
    end
  end

  `RUCI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNTW'(DEPTH))
  `RUCI_ASSERT_NXT(a_cnt_inc, push_ok && !pop_ok, cnt_r == CNTW'($past(cnt_r) + 1'b1))
  `RUCI_ASSERT_NXT(a_cnt_dec, pop_ok && !push_ok, cnt_r == CNTW'($past(cnt_r) - 1'b1))

endmodule

// ----- rtl/ruci_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: q = n * 2^FB / d.
module ruci_div import ruci_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [CW-1:0] d,
  output logic [NB-1:0] q
);

  logic [CW-1:0] rem_r [NB];
  logic [NB-1:0] quo_r [NB];
  logic [NB-1:0] dvd_r [NB];
  logic [CW-1:0] den_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [CW-1:0] rem_p, den_p;
    logic [NB-1:0] quo_p, dvd_p;
    logic [CW:0]   trial, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign quo_p = '0;
      assign dvd_p = {n, {FB{1'b0}}};
      assign den_p = d;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign quo_p = quo_r[k-1];
      assign dvd_p = dvd_r[k-1];
      assign den_p = den_r[k-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign trial = {rem_p, dvd_p[NB-1]};
    assign ge    = (trial >= {1'b0, den_p});
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[CW-1:0] : trial[CW-1:0];
        quo_r[k] <= {quo_p[NB-2:0], ge};
        dvd_r[k] <= {dvd_p[NB-2:0], 1'b0};
        den_r[k] <= den_p;
      end
    end
  end

  assign q = quo_r[NB-1];

endmodule

// ----- rtl/ruci_back.sv -----
// Back end: slab division, entry/exit selection, hit point, UV and result register.
`include "ray_unit_cube_intersect_macros.svh"
module ruci_back import ruci_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  output logic      q_pop,
  input  ruci_cls_t q_data,
  input  logic      q_empty,
  output logic      empty,
  input  logic      pop,
  output ruci_out_t out_data
);

  localparam int EW = (NB > 63) ? NB : 63;
  localparam logic [TW-1:0]        TCAP   = TW'(1) << 62;
  localparam logic [60:0]          PCAP   = 61'(1) << 60;
  localparam logic signed [TW-1:0] TLIM   = TW'(1) << (CW - 1);
  localparam logic signed [62:0]   HALF63 = 63'(HALF);

  typedef struct packed {
    logic                 hit;
    logic signed [TW-1:0] t;
    logic [2:0]           face;
    logic [62:0]          tm;
    logic                 tneg;
    logic [2:0]           dneg;
    logic [2:0][CW-1:0]   dmag;
    logic [2:0][CW-1:0]   org;
  } ruci_hit_t;

  logic      en;
  logic      out_valid_r;
  ruci_out_t out_r, out_nxt;

  // Whole pipeline advances unless the result register is held
  assign en      = !out_valid_r || pop;
  assign q_pop   = en && !q_empty;
  assign empty   = !out_valid_r;
  assign out_data = out_r;

  // Slab dividers, with classified ray carried alongside
  logic [NB-1:0] qa [3];
  logic [NB-1:0] qb [3];
  ruci_cls_t     sd_r [NB];
  logic          vd_r [NB];

  for (genvar ax = 0; ax < 3; ax++) begin : g_div
    ruci_div u_div_a (.clk(clk), .en(en), .n(q_data.amag[ax]), .d(q_data.dmag[ax]),
                      .q(qa[ax]));
    ruci_div u_div_b (.clk(clk), .en(en), .n(q_data.bmag[ax]), .d(q_data.dmag[ax]),
                      .q(qb[ax]));
  end

  function automatic logic signed [TW-1:0] to_t(input logic [NB-1:0] qv, input logic neg);
    logic [EW-1:0] qe;
    logic [TW-1:0] m;
    qe = EW'(qv);
    m  = (qe >= (EW'(1) << 62)) ? TCAP : TW'(qe);
    return neg ? -m : m;
  endfunction

  function automatic logic [15:0] to_q16(input logic [FB:0] val);
    logic [31:0] x, y;
    x = 32'(val);
    y = (x >> SH_R) << SH_L;
    return (y > 32'hFFFF) ? 16'hFFFF : y[15:0];
  endfunction

  // Stage X1: signed, capped slab parameters
  logic signed [TW-1:0] ta_r [3];
  logic signed [TW-1:0] tb_r [3];
  ruci_cls_t            s1_r;
  logic                 v1_r;

  // Stage X2: entry and exit
  logic signed [TW-1:0] tn_r, tf_r, tn_c, tf_c;
  logic [2:0]           fn_r, ff_r, fn_c, ff_c;
  logic                 nv_r, nv_c;
  ruci_cls_t            s2_r;
  logic                 v2_r;

  // Stage X3 onward
  ruci_hit_t h3_c, h3_r, h4_r, h5_r, h6_r;
  logic      v3_r, v4_r, v5_r, v6_r, v7_r;

  // Multiplier stages
  logic [63:0]  pll_r [3];
  logic [63:0]  plh_r [3];
  logic [63:0]  phl_r [3];
  logic [63:0]  phh_r [3];
  logic [63:0]  pll2_r [3];
  logic [64:0]  mid_r [3];
  logic [63:0]  phh2_r [3];
  logic [60:0]  m_r [3], m_c [3];

  // Stage P1
  logic signed [CW-1:0] pt_r [3], pt_c [3];
  logic signed [CW-1:0] tsat_r, tsat_c;
  logic [2:0]           face7_r;
  logic                 hit7_r;

  // Entry / exit selection, earlier axis wins ties
  always_comb begin
    logic signed [TW-1:0] lo, hi;
    logic [2:0]           nf, xf;
    tn_c = '0;
    tf_c = '0;
    fn_c = FACE_NX;
    ff_c = FACE_NX;
    nv_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s1_r.dneg[i]) begin
        lo = tb_r[i];
        hi = ta_r[i];
      end else begin
        lo = ta_r[i];
        hi = tb_r[i];
      end
      nf = {2'(i), s1_r.dneg[i]};
      xf = {2'(i), !s1_r.dneg[i]};
      if (!s1_r.dzero[i]) begin
        if (!nv_c || (lo > tn_c)) begin
          tn_c = lo;
          fn_c = nf;
        end
        if (!nv_c || (hi < tf_c)) begin
          tf_c = hi;
          ff_c = xf;
        end
        nv_c = 1'b1;
      end
    end
  end

  // Miss decision and choice of t
  always_comb begin
    logic signed [TW-1:0] nt;
    h3_c      = '0;
    h3_c.hit  = !(s2_r.par_miss || !nv_r || (tn_r > tf_r) || tf_r[TW-1]);
    h3_c.t    = tn_r[TW-1] ? tf_r : tn_r;
    h3_c.face = tn_r[TW-1] ? ff_r : fn_r;
    nt        = -h3_c.t;
    h3_c.tm   = h3_c.t[TW-1] ? nt[62:0] : h3_c.t[62:0];
    h3_c.tneg = h3_c.t[TW-1];
    h3_c.dneg = s2_r.dneg;
    h3_c.dmag = s2_r.dmag;
    h3_c.org  = s2_r.org;
  end

  // Product assembly: floor(|t| * |d| / 2^FB), capped at 2^60
  always_comb begin
    logic [127:0] fullp, sh;
    for (int i = 0; i < 3; i++) begin
      fullp = {phh2_r[i], 64'b0} + 128'({mid_r[i], 32'b0}) + 128'(pll2_r[i]);
      sh    = fullp >> FB;
      m_c[i] = (sh > 128'(PCAP)) ? PCAP : sh[60:0];
    end
  end

  // Hit point, clamp to the cube, face plane, t saturation
  always_comb begin
    logic signed [62:0] oe, me, sum;
    for (int i = 0; i < 3; i++) begin
      oe  = {{(63 - CW){h6_r.org[i][CW-1]}}, h6_r.org[i]};
      me  = {2'b00, m_r[i]};
      sum = (h6_r.tneg ^ h6_r.dneg[i]) ? oe - me : oe + me;
      if (sum < -HALF63) begin
        pt_c[i] = -HALF;
      end else if (sum > HALF63) begin
        pt_c[i] = HALF;
      end else begin
        pt_c[i] = sum[CW-1:0];
      end
      if (h6_r.face[2:1] == 2'(i)) begin
        pt_c[i] = h6_r.face[0] ? HALF : -HALF;
      end
    end
    if (h6_r.t >= TLIM) begin
      tsat_c = CW'(TLIM - 1);
    end else if (h6_r.t < -TLIM) begin
      tsat_c = CW'(-TLIM);
    end else begin
      tsat_c = h6_r.t[CW-1:0];
    end
  end

  // Cube-map UV and result assembly
  always_comb begin
    ruci_uv_sel_t         s;
    logic signed [CW-1:0] pu, pv;
    logic [CW:0]          su, sv;
    logic [FB:0]          au, av;
    s  = uv_sel(face7_r);
    pu = pt_r[s.uax];
    pv = pt_r[s.vax];
    su = {pu[CW-1], pu} + {1'b0, HALF};
    sv = {pv[CW-1], pv} + {1'b0, HALF};
    au = (su[FB:0] >> 2) + (FB+1)'(s.uoff) * QUARTER[FB:0];
    av = (sv[FB:0] >> 2) + (FB+1)'(s.voff) * QUARTER[FB:0];
    out_nxt = '0;
    if (hit7_r) begin
      out_nxt.hit     = 1'b1;
      out_nxt.t_hit   = tsat_r;
      out_nxt.face    = face7_r;
      out_nxt.point_x = pt_r[0];
      out_nxt.point_y = pt_r[1];
      out_nxt.point_z = pt_r[2];
      out_nxt.tex_u   = to_q16(au);
      out_nxt.tex_v   = to_q16(av);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r        <= '{default: 1'b0};
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vd_r[0] <= q_pop;
      for (int k = 1; k < NB; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
      v1_r        <= vd_r[NB-1];
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= q_data;
      for (int k = 1; k < NB; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        ta_r[i] <= to_t(qa[i], sd_r[NB-1].aneg[i] ^ sd_r[NB-1].dneg[i]);
        tb_r[i] <= to_t(qb[i], sd_r[NB-1].bneg[i] ^ sd_r[NB-1].dneg[i]);
      end
      s1_r <= sd_r[NB-1];
      tn_r <= tn_c;
      tf_r <= tf_c;
      fn_r <= fn_c;
      ff_r <= ff_c;
      nv_r <= nv_c;
      s2_r <= s1_r;
      h3_r <= h3_c;
      for (int i = 0; i < 3; i++) begin
        pll_r[i]  <= {32'b0, h3_r.tm[31:0]} * {32'b0, h3_r.dmag[i][31:0]};
        plh_r[i]  <= {32'b0, h3_r.tm[31:0]} * {32'b0, 32'(64'(h3_r.dmag[i]) >> 32)};
        phl_r[i]  <= {33'b0, h3_r.tm[62:32]} * {32'b0, h3_r.dmag[i][31:0]};
        phh_r[i]  <= {33'b0, h3_r.tm[62:32]} * {32'b0, 32'(64'(h3_r.dmag[i]) >> 32)};
        pll2_r[i] <= pll_r[i];
        mid_r[i]  <= 65'(plh_r[i]) + 65'(phl_r[i]);
        phh2_r[i] <= phh_r[i];
        m_r[i]    <= m_c[i];
        pt_r[i]   <= pt_c[i];
      end
      h4_r    <= h3_r;
      h5_r    <= h4_r;
      h6_r    <= h5_r;
      tsat_r  <= tsat_c;
      face7_r <= h6_r.face;
      hit7_r  <= h6_r.hit;
      out_r   <= out_nxt;
    end
  end

  `RUCI_ASSERT_IMP(a_miss_zero, out_valid_r && !out_r.hit, (out_r.t_hit == '0) && (out_r.face == FACE_NX) && (out_r.tex_u == '0))
  `RUCI_ASSERT_IMP(a_face_range, out_valid_r && out_r.hit, out_r.face <= FACE_PZ)
  `RUCI_ASSERT_IMP(a_x_plane, out_valid_r && out_r.hit && (out_r.face == FACE_NX || out_r.face == FACE_PX), out_r.point_x == ((out_r.face == FACE_PX) ? HALF : -HALF))

endmodule
